// ===== rtl/core/dertlv_pkg.sv =====
// Shared types and constants for the DER TLV header parser.
package dertlv_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_TAG    = 3'd2;
    localparam logic [2:0] ST_LENLEN = 3'd3;
    localparam logic [2:0] ST_LEN    = 3'd4;

    // Encoding constants of the length octet
    localparam logic [7:0] LEN_LONG_BIT  = 8'h80;
    localparam logic [6:0] LEN_COUNT_MSK = 7'h7f;
    localparam logic [7:0] HDR_SHORT_LEN = 8'd2;
    localparam logic [31:0] MIN_CURSOR   = 32'd2;

    // One input request
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_object;
        logic [31:0] cursor_len;
        logic [31:0] extra_len;
        logic [7:0]  expected_tag;
        logic        match_any;
    } dertlv_in_t;

    // One result
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  tag_seen;
        logic [31:0] body_len;
        logic [7:0]  hdr_bytes;
        logic [31:0] body_in_cursor;
        logic [31:0] extra_out;
    } dertlv_out_t;

endpackage

// ===== rtl/core/dertlv_finish.sv =====
// Final length check and split of the body between cursor and extra.
module dertlv_finish
    import dertlv_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  logic [LEN_BITS-1:0] len,
    input  logic [31:0]         bytes_left,
    input  logic [32:0]         room,
    input  logic [7:0]          tag,
    input  logic [7:0]          hdr_len,
    output dertlv_out_t         result
);

    localparam int CMP_W = (LEN_BITS > 33) ? LEN_BITS : 33;

    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] room_ext;
    logic [CMP_W-1:0] left_ext;
    logic [CMP_W-1:0] in_cursor;
    logic [CMP_W-1:0] beyond;

    // Widen all operands to a common compare width.
    assign len_ext  = CMP_W'(len);
    assign room_ext = CMP_W'(room);
    assign left_ext = CMP_W'(bytes_left);

    // Body bytes inside the cursor and those beyond it.
    assign in_cursor = (len_ext <= left_ext) ? len_ext : left_ext;
    assign beyond    = len_ext - in_cursor;

    // A body longer than the cursor plus the extra is an overrun.
    always_comb begin
        result.tag_seen  = tag;
        result.body_len  = len_ext[31:0];
        result.hdr_bytes = hdr_len;
        if (room_ext < len_ext) begin
            result.status         = ST_LEN;
            result.body_in_cursor = '0;
            result.extra_out      = '0;
        end else begin
            result.status         = ST_OK;
            result.body_in_cursor = in_cursor[31:0];
            result.extra_out      = beyond[31:0];
        end
    end

endmodule

// ===== rtl/core/der_tlv_header_parser.sv =====
// DER TLV header parser top level: byte-serial tag and length decoding.
// A request that completes a header gives its registered result in the cycle after acceptance.
// Throughput: one byte request per cycle while the output register is empty or m_ready is high; else s_ready stalls.
// Parse state updates when each byte is accepted; no multi-cycle unit exists.
// Reset (aresetn, synchronous, active low) clears the parse phase and the result valid.
// Payload registers are not reset; parse registers reload at the tag byte of each object that passes its checks.
module der_tlv_header_parser
    import dertlv_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dertlv_in_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dertlv_out_t m_data
);

    // Parse phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN1 = 2'd1;
    localparam logic [1:0] PH_LENN = 2'd2;

    logic [1:0]          phase_reg, phase_next;
    logic [LEN_BITS-1:0] accum_reg, accum_next;
    logic [6:0]          lbl_reg, lbl_next;
    logic [31:0]         left_reg, left_next;
    logic [32:0]         room_reg, room_next;
    logic [7:0]          tag_reg, tag_next;
    logic [7:0]          hcnt_reg, hcnt_next;
    logic                m_valid_reg;
    dertlv_out_t         m_data_reg;

    logic                accept;
    logic                res_valid;
    logic                use_finish;
    dertlv_out_t         res_direct;
    dertlv_out_t         res_finish;
    dertlv_out_t         res;
    logic [LEN_BITS-1:0] fin_len;
    logic [6:0]          len_count;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign len_count = s_data.data_byte[6:0] & LEN_COUNT_MSK;

    // Next parse state and the result a byte may cause
    always_comb begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        lbl_next   = lbl_reg;
        left_next  = left_reg;
        room_next  = room_reg;
        tag_next   = tag_reg;
        hcnt_next  = hcnt_reg;
        res_valid  = 1'b0;
        use_finish = 1'b0;
        fin_len    = '0;
        res_direct = '0;
        if (s_data.start_object) begin
            phase_next          = PH_IDLE;
            res_direct.tag_seen = s_data.data_byte;
            if (s_data.cursor_len < MIN_CURSOR) begin
                res_valid         = 1'b1;
                res_direct.status = ST_EMPTY;
            end else if (!s_data.match_any && (s_data.expected_tag != s_data.data_byte)) begin
                res_valid         = 1'b1;
                res_direct.status = ST_TAG;
            end else begin
                tag_next   = s_data.data_byte;
                left_next  = s_data.cursor_len - 32'd1;
                room_next  = {1'b0, left_next} + {1'b0, s_data.extra_len};
                hcnt_next  = 8'd1;
                accum_next = '0;
                lbl_next   = '0;
                phase_next = PH_LEN1;
            end
        end else begin
            unique case (phase_reg)
                PH_LEN1: begin
                    left_next  = left_reg - 32'd1;
                    room_next  = room_reg - 33'd1;
                    hcnt_next  = HDR_SHORT_LEN;
                    phase_next = PH_IDLE;
                    if ((s_data.data_byte & LEN_LONG_BIT) != 8'd0) begin
                        if (left_next < 32'(len_count)) begin
                            res_valid            = 1'b1;
                            res_direct.status    = ST_LENLEN;
                            res_direct.tag_seen  = tag_reg;
                            res_direct.hdr_bytes = HDR_SHORT_LEN;
                        end else if (len_count == 7'd0) begin
                            accum_next = '0;
                            res_valid  = 1'b1;
                            use_finish = 1'b1;
                        end else begin
                            accum_next = '0;
                            lbl_next   = len_count;
                            phase_next = PH_LENN;
                        end
                    end else begin
                        accum_next = LEN_BITS'(s_data.data_byte);
                        fin_len    = LEN_BITS'(s_data.data_byte);
                        res_valid  = 1'b1;
                        use_finish = 1'b1;
                    end
                end
                PH_LENN: begin
                    accum_next = {accum_reg[LEN_BITS-9:0], s_data.data_byte};
                    fin_len    = accum_next;
                    left_next  = left_reg - 32'd1;
                    room_next  = room_reg - 33'd1;
                    hcnt_next  = hcnt_reg + 8'd1;
                    lbl_next   = lbl_reg - 7'd1;
                    if (lbl_next == 7'd0) begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        use_finish = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Length check against the cursor and the extra
    dertlv_finish #(
        .LEN_BITS(LEN_BITS)
    ) u_finish (
        .len        (fin_len),
        .bytes_left (left_next),
        .room       (room_next),
        .tag        (tag_reg),
        .hdr_len    (hcnt_next),
        .result     (res_finish)
    );

    assign res = use_finish ? res_finish : res_direct;

    // Parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            accum_reg <= accum_next;
            lbl_reg   <= lbl_next;
            left_reg  <= left_next;
            room_reg  <= room_next;
            tag_reg   <= tag_next;
            hcnt_reg  <= hcnt_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An empty object answers in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.start_object && (s_data.cursor_len < MIN_CURSOR))
        |=> (m_valid && (m_data.status == ST_EMPTY)))
        else $error("empty object did not give an empty result");

    // While collecting long-form bytes, some remain to be read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LENN) |-> (lbl_reg != 7'd0))
        else $error("long-form phase with no length bytes left");

    // A good result splits the body exactly between cursor and extra and counts a header of at least two bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_OK))
        |-> ((m_data.body_in_cursor + m_data.extra_out) == m_data.body_len)
            && (m_data.hdr_bytes >= HDR_SHORT_LEN))
        else $error("inconsistent good result");

    // A length-field overrun carries no body length and reports the short header size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_LENLEN))
        |-> ((m_data.body_len == 32'd0) && (m_data.hdr_bytes == HDR_SHORT_LEN)))
        else $error("malformed length-field overrun result");

endmodule
